@@ hdl/ray_box_slab_intersect_top_defines.svh @@
// assertion helpers for the slab intersect top level
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_DEFINES_SVH

// same-cycle implication
`define RBS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RBS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/rbs_pkg.sv @@
`default_nettype none
package rbs_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DIR_W           = 18;
  localparam int DIR_FRAC        = 16;
  localparam int TOL_W           = 16;
  localparam int TOL_FRAC        = 16;
  localparam int NUM_AXES        = 3;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  typedef struct packed {
    logic parallel;
    logic outside;
  } rbs_lane_flags_t;

  typedef struct packed {
    logic hit;
    logic in_box;
  } rbs_res_flags_t;

endpackage
`default_nettype wire

@@ hdl/rbs_ifs.sv @@
`default_nettype none
interface rbs_in_if import rbs_pkg::*; #(parameter int CW = COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic signed [CW-1:0] origin_x;
  logic signed [CW-1:0] origin_y;
  logic signed [CW-1:0] origin_z;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [DIR_W-1:0] dir_z;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_min_z;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_max_y;
  logic signed [CW-1:0] box_max_z;
  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  input ready);
  modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                output ready);
endinterface

interface rbs_out_if import rbs_pkg::*; #(parameter int CW = COORD_WIDTH_DEF);
  logic valid;
  logic ready;
  logic hit;
  logic inside_res;
  logic [CW-2:0] enter_dist;
  logic [CW-2:0] exit_dist;
  modport source (output valid, hit, inside_res, enter_dist, exit_dist, input ready);
  modport sink (input valid, hit, inside_res, enter_dist, exit_dist, output ready);
endinterface

interface rbs_cfg_if import rbs_pkg::*;;
  logic valid;
  logic ready;
  logic [TOL_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

@@ hdl/ray_box_slab_intersect_top.sv @@
// channel   dir  beat contents
// in_ch     in   ray origin, direction, box min and max corners
// out_ch    out  hit, inside_res, enter_dist, exit_dist
// cfg_ch    in   tolerance
//
// one beat per cycle sustained while out_ch is ready
// each axis lane holds slab dividers that resolve one quotient bit per stage
// synchronous active-low reset clears the valid bits and skid flag and loads tolerance with TOL_RESET
// an output stall is absorbed by a one-beat skid, then the whole pipe holds
`default_nettype none
`include "ray_box_slab_intersect_top_defines.svh"
module ray_box_slab_intersect_top import rbs_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rbs_in_if.sink     in_ch,
  rbs_out_if.source  out_ch,
  rbs_cfg_if.sink    cfg_ch
);

  localparam int CW = COORD_WIDTH;
  localparam int S  = CW + 5;

  logic [TOL_W-1:0] tol_r;
  logic [S-1:0] v_r;
  logic skid_v_r;
  logic en;

  assign en           = !skid_v_r;
  assign in_ch.ready  = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_ch.valid) begin
      tol_r <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[S-2:0], in_ch.valid};
    end
  end

  logic signed [CW-1:0] o_a [NUM_AXES];
  logic signed [DIR_W-1:0] d_a [NUM_AXES];
  logic signed [CW-1:0] lo_a [NUM_AXES];
  logic signed [CW-1:0] hi_a [NUM_AXES];
  logic signed [CW-1:0] tmin_a [NUM_AXES];
  logic signed [CW-1:0] tmax_a [NUM_AXES];
  rbs_lane_flags_t fl_a [NUM_AXES];

  assign o_a[0]  = in_ch.origin_x;
  assign o_a[1]  = in_ch.origin_y;
  assign o_a[2]  = in_ch.origin_z;
  assign d_a[0]  = in_ch.dir_x;
  assign d_a[1]  = in_ch.dir_y;
  assign d_a[2]  = in_ch.dir_z;
  assign lo_a[0] = in_ch.box_min_x;
  assign lo_a[1] = in_ch.box_min_y;
  assign lo_a[2] = in_ch.box_min_z;
  assign hi_a[0] = in_ch.box_max_x;
  assign hi_a[1] = in_ch.box_max_y;
  assign hi_a[2] = in_ch.box_max_z;

  genvar a;
  for (a = 0; a < NUM_AXES; a++) begin : g_lane
    rbs_lane #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .tol   (tol_r),
      .o     (o_a[a]),
      .d     (d_a[a]),
      .lo    (lo_a[a]),
      .hi    (hi_a[a]),
      .t_min (tmin_a[a]),
      .t_max (tmax_a[a]),
      .flags (fl_a[a])
    );
  end

  rbs_res_flags_t res;
  logic [CW-2:0] enter_d, exit_d;

  rbs_merge #(.CW(CW), .FRAC_BITS(FRAC_BITS)) u_merge (
    .clk        (clk),
    .en         (en),
    .tol        (tol_r),
    .t_min      (tmin_a),
    .t_max      (tmax_a),
    .flags      (fl_a),
    .res        (res),
    .enter_dist (enter_d),
    .exit_dist  (exit_d)
  );

  // output skid
  rbs_res_flags_t skid_res_r;
  logic [CW-2:0] skid_enter_r, skid_exit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ch.ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (v_r[S-1] && !out_ch.ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_res_r   <= res;
      skid_enter_r <= enter_d;
      skid_exit_r  <= exit_d;
    end
  end

  assign out_ch.valid      = skid_v_r || v_r[S-1];
  assign out_ch.hit        = skid_v_r ? skid_res_r.hit : res.hit;
  assign out_ch.inside_res = skid_v_r ? skid_res_r.in_box : res.in_box;
  assign out_ch.enter_dist = skid_v_r ? skid_enter_r : enter_d;
  assign out_ch.exit_dist  = skid_v_r ? skid_exit_r : exit_d;

  `RBS_ASSERT_IMP(a_miss_zero, out_ch.valid && !out_ch.hit, !out_ch.inside_res && out_ch.enter_dist == '0 && out_ch.exit_dist == '0, "miss beat carries nonzero fields")
  `RBS_ASSERT_IMP(a_inside_hit, out_ch.valid && out_ch.inside_res, out_ch.hit && out_ch.enter_dist == '0, "inside beat without hit or with entry distance")
  `RBS_ASSERT_IMP(a_order, out_ch.valid && out_ch.hit, out_ch.exit_dist >= out_ch.enter_dist, "exit before entry on hit")
  `RBS_ASSERT_NXT(a_skid_take, !skid_v_r && v_r[S-1] && !out_ch.ready, skid_v_r, "stalled result not kept in skid")

endmodule
`default_nettype wire

@@ hdl/rbs_lane.sv @@
`default_nettype none
module rbs_lane import rbs_pkg::*; #(
  parameter int CW        = COORD_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [TOL_W-1:0]       tol,
  input  logic signed [CW-1:0]   o,
  input  logic signed [DIR_W-1:0] d,
  input  logic signed [CW-1:0]   lo,
  input  logic signed [CW-1:0]   hi,
  output logic signed [CW-1:0]   t_min,
  output logic signed [CW-1:0]   t_max,
  output rbs_lane_flags_t        flags
);

  localparam int QW = CW - 1;
  localparam int NW = CW + 1 + DIR_FRAC;
  localparam int RW = NW + 1;
  localparam int PW = TOL_W + CW;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  // stage 0: differences and magnitudes
  logic [CW:0] dl, dh, dlm, dhm;
  logic [CW-1:0] mlo, mhi;
  logic [DIR_W-1:0] dmag;

  assign dl   = {lo[CW-1], lo} - {o[CW-1], o};
  assign dh   = {hi[CW-1], hi} - {o[CW-1], o};
  assign dlm  = dl[CW] ? (~dl + 1'b1) : dl;
  assign dhm  = dh[CW] ? (~dh + 1'b1) : dh;
  assign mlo  = lo[CW-1] ? (~lo + 1'b1) : lo;
  assign mhi  = hi[CW-1] ? (~hi + 1'b1) : hi;
  assign dmag = d[DIR_W-1] ? (~d + 1'b1) : d;

  logic [CW:0] dlm_r, dhm_r;
  logic nl0_r, nh0_r, dz0_r;
  logic [DIR_W-1:0] dm0_r;
  logic [CW-1:0] sm_r;
  logic signed [CW-1:0] o0_r, lo0_r, hi0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dlm_r <= dlm;
      dhm_r <= dhm;
      nl0_r <= dl[CW] != d[DIR_W-1];
      nh0_r <= dh[CW] != d[DIR_W-1];
      dz0_r <= d == '0;
      dm0_r <= dmag;
      sm_r  <= (mlo > mhi) ? mlo : mhi;
      o0_r  <= o;
      lo0_r <= lo;
      hi0_r <= hi;
    end
  end

  // stage 1: tolerance scale, overflow check, division setup
  logic [CW-1:0] sm_sel;
  logic [PW-1:0] prod;
  logic [NW-1:0] nl_n, nh_n;
  logic [RW-1:0] dlim;

  assign sm_sel = (sm_r > ONE) ? sm_r : ONE;
  assign prod   = PW'(tol) * PW'(sm_sel);
  assign nl_n   = {dlm_r, {DIR_FRAC{1'b0}}};
  assign nh_n   = {dhm_r, {DIR_FRAC{1'b0}}};
  assign dlim   = RW'(dm0_r) << QW;

  logic [RW-1:0] rl_r [0:QW];
  logic [RW-1:0] rh_r [0:QW];
  logic [QW-1:0] ql_r [0:QW];
  logic [QW-1:0] qh_r [0:QW];
  logic [DIR_W-1:0] dm_r [0:QW];
  logic nl_p [0:QW];
  logic nh_p [0:QW];
  logic ol_p [0:QW];
  logic oh_p [0:QW];
  logic dz_p [0:QW];
  logic outs_p [1:QW];
  logic [CW-1:0] tol1_r;
  logic signed [CW-1:0] o1_r, lo1_r, hi1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rl_r[0] <= RW'(nl_n);
      rh_r[0] <= RW'(nh_n);
      ql_r[0] <= '0;
      qh_r[0] <= '0;
      dm_r[0] <= dm0_r;
      nl_p[0] <= nl0_r;
      nh_p[0] <= nh0_r;
      ol_p[0] <= RW'(nl_n) >= dlim;
      oh_p[0] <= RW'(nh_n) >= dlim;
      dz_p[0] <= dz0_r;
      tol1_r  <= prod[PW-1:TOL_FRAC];
      o1_r    <= o0_r;
      lo1_r   <= lo0_r;
      hi1_r   <= hi0_r;
    end
  end

  // slab test against the tolerant bounds
  logic signed [CW+1:0] o_e, lo_m, hi_p;
  logic outside;

  assign o_e     = {{2{o1_r[CW-1]}}, o1_r};
  assign lo_m    = {{2{lo1_r[CW-1]}}, lo1_r} - {2'b00, tol1_r};
  assign hi_p    = {{2{hi1_r[CW-1]}}, hi1_r} + {2'b00, tol1_r};
  assign outside = (o_e < lo_m) || (o_e > hi_p);

  // restoring division, one quotient bit per stage
  genvar j;
  for (j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0] trial;
    logic gel, geh;

    assign trial = RW'(dm_r[j]) << (QW - 1 - j);
    assign gel   = rl_r[j] >= trial;
    assign geh   = rh_r[j] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rl_r[j+1] <= gel ? (rl_r[j] - trial) : rl_r[j];
        rh_r[j+1] <= geh ? (rh_r[j] - trial) : rh_r[j];
        ql_r[j+1] <= {ql_r[j][QW-2:0], gel};
        qh_r[j+1] <= {qh_r[j][QW-2:0], geh};
        dm_r[j+1] <= dm_r[j];
        nl_p[j+1] <= nl_p[j];
        nh_p[j+1] <= nh_p[j];
        ol_p[j+1] <= ol_p[j];
        oh_p[j+1] <= oh_p[j];
        dz_p[j+1] <= dz_p[j];
      end
    end

    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          outs_p[1] <= outside;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en) begin
          outs_p[j+1] <= outs_p[j];
        end
      end
    end
  end

  // sign, saturate and order
  function automatic logic signed [CW-1:0] sat_q(input logic [QW-1:0] q,
                                                 input logic ovf, input logic neg);
    logic signed [CW-1:0] qs;
    qs = {1'b0, q};
    if (ovf) begin
      return neg ? T_MIN : T_MAX;
    end
    return neg ? -qs : qs;
  endfunction

  logic signed [CW-1:0] t1, t2;
  logic signed [CW-1:0] t_min_r, t_max_r;
  rbs_lane_flags_t flags_r;

  assign t1 = sat_q(ql_r[QW], ol_p[QW], nl_p[QW]);
  assign t2 = sat_q(qh_r[QW], oh_p[QW], nh_p[QW]);

  always_ff @(posedge clk) begin
    if (en) begin
      t_min_r          <= (t1 > t2) ? t2 : t1;
      t_max_r          <= (t1 > t2) ? t1 : t2;
      flags_r.parallel <= dz_p[QW];
      flags_r.outside  <= outs_p[QW];
    end
  end

  assign t_min = t_min_r;
  assign t_max = t_max_r;
  assign flags = flags_r;

endmodule
`default_nettype wire

@@ hdl/rbs_merge.sv @@
`default_nettype none
module rbs_merge import rbs_pkg::*; #(
  parameter int CW        = COORD_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [TOL_W-1:0]     tol,
  input  logic signed [CW-1:0] t_min [NUM_AXES],
  input  logic signed [CW-1:0] t_max [NUM_AXES],
  input  rbs_lane_flags_t      flags [NUM_AXES],
  output rbs_res_flags_t       res,
  output logic [CW-2:0]        enter_dist,
  output logic [CW-2:0]        exit_dist
);

  localparam int PW = TOL_W + CW;
  localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

  // stage a: fold the lane intervals
  logic signed [CW-1:0] ent_c, ext_c;
  logic miss_c, inside_c;

  always_comb begin
    ent_c    = T_MIN;
    ext_c    = T_MAX;
    miss_c   = 1'b0;
    inside_c = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (flags[a].outside) begin
        inside_c = 1'b0;
      end
      if (flags[a].parallel) begin
        if (flags[a].outside) begin
          miss_c = 1'b1;
        end
      end else begin
        if (t_min[a] > ent_c) begin
          ent_c = t_min[a];
        end
        if (t_max[a] < ext_c) begin
          ext_c = t_max[a];
        end
      end
    end
  end

  logic signed [CW-1:0] ent_a_r, ext_a_r;
  logic miss_a_r, inside_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ent_a_r    <= ent_c;
      ext_a_r    <= ext_c;
      miss_a_r   <= miss_c || (ent_c > ext_c);
      inside_a_r <= inside_c;
    end
  end

  // stage b: tolerances of both ends
  logic [CW-1:0] me, mx, se, sx;
  logic [PW-1:0] pe, px;

  assign me = ent_a_r[CW-1] ? (~ent_a_r + 1'b1) : ent_a_r;
  assign mx = ext_a_r[CW-1] ? (~ext_a_r + 1'b1) : ext_a_r;
  assign se = (me > ONE) ? me : ONE;
  assign sx = (mx > ONE) ? mx : ONE;
  assign pe = PW'(tol) * PW'(se);
  assign px = PW'(tol) * PW'(sx);

  logic signed [CW-1:0] ent_b_r, ext_b_r;
  logic [CW-1:0] tol_e_r, tol_x_r;
  logic miss_b_r, inside_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ent_b_r    <= ent_a_r;
      ext_b_r    <= ext_a_r;
      tol_e_r    <= pe[PW-1:TOL_FRAC];
      tol_x_r    <= px[PW-1:TOL_FRAC];
      miss_b_r   <= miss_a_r;
      inside_b_r <= inside_a_r;
    end
  end

  // stage c: behind-origin check and result forming
  logic signed [CW:0] xe, ee, ntol, ptol;
  logic miss_f, near;

  assign xe     = {ext_b_r[CW-1], ext_b_r};
  assign ee     = {ent_b_r[CW-1], ent_b_r};
  assign ptol   = {1'b0, tol_e_r};
  assign ntol   = -{1'b0, tol_x_r};
  assign miss_f = miss_b_r || (xe < ntol);
  assign near   = ee <= ptol;

  rbs_res_flags_t res_r;
  logic [CW-2:0] enter_r, exit_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (miss_f) begin
        res_r   <= '0;
        enter_r <= '0;
        exit_r  <= '0;
      end else if (near) begin
        res_r.hit    <= 1'b1;
        res_r.in_box <= inside_b_r;
        enter_r      <= '0;
        exit_r       <= (ext_b_r > 0) ? ext_b_r[CW-2:0] : '0;
      end else begin
        res_r.hit    <= 1'b1;
        res_r.in_box <= 1'b0;
        enter_r      <= ent_b_r[CW-2:0];
        exit_r       <= ext_b_r[CW-2:0];
      end
    end
  end

  assign res        = res_r;
  assign enter_dist = enter_r;
  assign exit_dist  = exit_r;

endmodule
`default_nettype wire
